FILE: rtl/mlfq_pkg.sv
// Shared constants and types for the feedback-queue slice scheduler.
package mlfq_pkg;

   localparam int MAX_JOBS_DEF = 16;
   localparam int DATA_W       = 16;
   localparam int TIME_W       = 32;
   localparam int LVL_W        = 2;
   localparam int CSR_IDX_W    = 3;
   localparam int BOOST_W      = 17;

   localparam logic [DATA_W-1:0] QUANTUM_TOP_RST      = 16'd5;
   localparam logic [DATA_W-1:0] ALLOTMENT_TOP_RST    = 16'd10;
   localparam logic [DATA_W-1:0] QUANTUM_MIDDLE_RST   = 16'd8;
   localparam logic [DATA_W-1:0] ALLOTMENT_MIDDLE_RST = 16'd24;
   localparam logic [DATA_W-1:0] QUANTUM_BOTTOM_RST   = 16'd20;
   localparam logic [DATA_W-1:0] BOOST_PERIOD_RST     = 16'd40;

   localparam logic CMD_ADMIT = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [LVL_W-1:0] LVL_TOP    = 2'd0;
   localparam logic [LVL_W-1:0] LVL_MIDDLE = 2'd1;
   localparam logic [LVL_W-1:0] LVL_BOTTOM = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUANTUM_TOP      = 3'd0,
      CSR_ALLOTMENT_TOP    = 3'd1,
      CSR_QUANTUM_MIDDLE   = 3'd2,
      CSR_ALLOTMENT_MIDDLE = 3'd3,
      CSR_QUANTUM_BOTTOM   = 3'd4,
      CSR_BOOST_PERIOD     = 3'd5
   } csr_reg_type;

endpackage

FILE: rtl/mlfq_ram.sv
// Generic simple dual-port RAM, one write port, registered read.
module mlfq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/mlfq_slice_scheduler_unit.sv
// Top level of the three-level feedback-queue slice scheduler.
// An admit, unless all slots are held, writes the job memory and the top queue, first
// popping a slot from the free-slot stack once no fresh slot is left. A step that runs a
// slice reads the queue, then the job memory, then writes both back; an empty step uses
// neither memory; a boost moves each middle and bottom job to the top level in turn.
// These steps follow the read-modify-write round trips through the job memory and the
// queue memory, one access each per cycle. The result strobe lasts one cycle and cannot
// be held off; the next start may be taken in the cycle the strobe shows.
module mlfq_slice_scheduler_unit #(
   parameter int MAX_JOBS = mlfq_pkg::MAX_JOBS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_command,
   input  logic [mlfq_pkg::DATA_W-1:0]      req_job_id,
   input  logic [mlfq_pkg::DATA_W-1:0]      req_job_length,
   output logic                             rsp_valid,
   output logic [mlfq_pkg::DATA_W-1:0]      rsp_served_id,
   output logic [mlfq_pkg::LVL_W-1:0]       rsp_served_level,
   output logic [mlfq_pkg::DATA_W-1:0]      rsp_slice_used,
   output logic [mlfq_pkg::DATA_W-1:0]      rsp_left_over,
   output logic                             rsp_finished,
   output logic                             rsp_boosted,
   output logic                             rsp_idle,
   output logic                             rsp_rejected,
   output logic [mlfq_pkg::TIME_W-1:0]      rsp_now_time,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mlfq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mlfq_pkg::DATA_W-1:0]      csr_wdata
);
   import mlfq_pkg::*;

   localparam int SLOT_W = $clog2(MAX_JOBS);
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);
   localparam int QDEPTH = 4 * MAX_JOBS;
   localparam int QA_W   = $clog2(QDEPTH);
   localparam int JOB_W  = 3 * DATA_W;

   // queue memory regions: three levels and the free-slot stack
   localparam logic [1:0] RGN_FREE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ADM, ST_ADM_POP, ST_STEP, ST_SL_JRD, ST_SL_EXE, ST_SL_WB,
      ST_BST_RD, ST_BST_JRD, ST_BST_WR
   } state_type;

   state_type state_ff, state_in;

   logic [DATA_W-1:0] q_top_ff, q_top_in, a_top_ff, a_top_in;
   logic [DATA_W-1:0] q_mid_ff, q_mid_in, a_mid_ff, a_mid_in;
   logic [DATA_W-1:0] q_bot_ff, q_bot_in, period_ff, period_in;

   logic              cmd_ff, cmd_in;
   logic [DATA_W-1:0] rid_ff, rid_in, rlen_ff, rlen_in;

   logic [SLOT_W-1:0] head_ff [3];
   logic [SLOT_W-1:0] head_in [3];
   logic [CNT_W-1:0]  cnt_ff [3];
   logic [CNT_W-1:0]  cnt_in [3];
   logic [CNT_W-1:0]  fresh_ff, fresh_in, free_cnt_ff, free_cnt_in, held_ff, held_in;
   logic [LVL_W-1:0]  cursor_ff, cursor_in, lvl_ff, lvl_in;
   logic [BOOST_W-1:0] bc_ff, bc_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [DATA_W-1:0] jid_ff, jid_in, jrem_ff, jrem_in, jused_ff, jused_in;
   logic [DATA_W-1:0] slice_ff, slice_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_id_ff, rsp_id_in, rsp_slice_ff, rsp_slice_in;
   logic [DATA_W-1:0] rsp_left_ff, rsp_left_in;
   logic [LVL_W-1:0]  rsp_lvl_ff, rsp_lvl_in;
   logic              rsp_fin_ff, rsp_fin_in, rsp_bst_ff, rsp_bst_in;
   logic              rsp_idle_ff, rsp_idle_in, rsp_rej_ff, rsp_rej_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;

   logic              j_we;
   logic [SLOT_W-1:0] j_waddr, j_raddr;
   logic [JOB_W-1:0]  j_wdata, j_rdata;
   logic              q_we;
   logic [QA_W-1:0]   q_waddr, q_raddr;
   logic [SLOT_W-1:0] q_wdata, q_rdata;

   function automatic logic [QA_W-1:0] qaddr(input logic [1:0] rgn,
                                             input logic [SLOT_W-1:0] ptr);
      logic [QA_W-1:0] base;
      case (rgn)
         2'd0:    base = '0;
         2'd1:    base = QA_W'(MAX_JOBS);
         2'd2:    base = QA_W'(2 * MAX_JOBS);
         default: base = QA_W'(3 * MAX_JOBS);
      endcase
      return base + QA_W'(ptr);
   endfunction

   function automatic logic [SLOT_W-1:0] ptr_add(input logic [SLOT_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
      if (s >= (CNT_W+1)'(MAX_JOBS)) begin
         s = s - (CNT_W+1)'(MAX_JOBS);
      end
      return s[SLOT_W-1:0];
   endfunction

   mlfq_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_job_ram (
      .clock(clock), .wr_en(j_we), .wr_addr(j_waddr), .wr_data(j_wdata),
      .rd_addr(j_raddr), .rd_data(j_rdata)
   );

   mlfq_ram #(.WIDTH(SLOT_W), .DEPTH(QDEPTH)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   always_comb begin
      logic              resp;
      logic [DATA_W-1:0] r_id, r_slice, r_left;
      logic [LVL_W-1:0]  r_lvl, sel_lvl, tgt;
      logic              r_fin, r_bst, r_rej, found, do_boost;
      logic [SLOT_W-1:0] nslot;
      logic [DATA_W-1:0] quant, allot, rem_new, used_new;
      logic [DATA_W:0]   used_sum;
      logic [BOOST_W:0]  bc_sum;
      logic              demote;

      state_in    = state_ff;
      q_top_in    = q_top_ff;  a_top_in = a_top_ff;
      q_mid_in    = q_mid_ff;  a_mid_in = a_mid_ff;
      q_bot_in    = q_bot_ff;  period_in = period_ff;
      cmd_in      = cmd_ff;    rid_in = rid_ff;  rlen_in = rlen_ff;
      head_in     = head_ff;   cnt_in = cnt_ff;
      fresh_in    = fresh_ff;  free_cnt_in = free_cnt_ff;  held_in = held_ff;
      cursor_in   = cursor_ff; lvl_in = lvl_ff;
      bc_in       = bc_ff;     time_in = time_ff;
      slot_in     = slot_ff;
      jid_in      = jid_ff;    jrem_in = jrem_ff;  jused_in = jused_ff;
      slice_in    = slice_ff;
      rsp_valid_in = 1'b0;
      rsp_id_in   = rsp_id_ff;  rsp_slice_in = rsp_slice_ff;
      rsp_left_in = rsp_left_ff; rsp_lvl_in = rsp_lvl_ff;
      rsp_fin_in  = rsp_fin_ff;  rsp_bst_in = rsp_bst_ff;
      rsp_idle_in = rsp_idle_ff; rsp_rej_in = rsp_rej_ff;
      rsp_time_in = rsp_time_ff;

      j_we = 1'b0; j_waddr = slot_ff; j_wdata = {jid_ff, jrem_ff, jused_ff};
      j_raddr = slot_ff;
      q_we = 1'b0; q_waddr = '0; q_wdata = slot_ff; q_raddr = '0;

      resp = 1'b0;
      r_id = '0; r_slice = '0; r_left = '0; r_lvl = '0;
      r_fin = 1'b0; r_bst = 1'b0; r_rej = 1'b0;
      nslot = q_rdata;
      tgt = lvl_ff;

      // first non-empty level at or after the cursor
      found = 1'b1;
      sel_lvl = LVL_BOTTOM;
      if (cursor_ff == LVL_TOP && cnt_ff[0] != '0) begin
         sel_lvl = LVL_TOP;
      end else if (cursor_ff != LVL_BOTTOM && cnt_ff[1] != '0) begin
         sel_lvl = LVL_MIDDLE;
      end else if (cnt_ff[2] != '0) begin
         sel_lvl = LVL_BOTTOM;
      end else begin
         found = 1'b0;
      end
      do_boost = !found || (bc_ff >= BOOST_W'(period_ff));

      case (lvl_ff)
         LVL_TOP:    quant = q_top_ff;
         LVL_MIDDLE: quant = q_mid_ff;
         default:    quant = q_bot_ff;
      endcase
      allot    = (lvl_ff == LVL_TOP) ? a_top_ff : a_mid_ff;
      rem_new  = jrem_ff - slice_ff;
      used_sum = {1'b0, jused_ff} + {1'b0, slice_ff};
      used_new = used_sum[DATA_W] ? {DATA_W{1'b1}} : used_sum[DATA_W-1:0];
      demote   = (lvl_ff != LVL_BOTTOM) && (used_new >= allot);
      bc_sum   = {1'b0, bc_ff} + (BOOST_W+1)'(slice_ff);

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_QUANTUM_TOP:      q_top_in  = csr_wdata;
                  CSR_ALLOTMENT_TOP:    a_top_in  = csr_wdata;
                  CSR_QUANTUM_MIDDLE:   q_mid_in  = csr_wdata;
                  CSR_ALLOTMENT_MIDDLE: a_mid_in  = csr_wdata;
                  CSR_QUANTUM_BOTTOM:   q_bot_in  = csr_wdata;
                  CSR_BOOST_PERIOD:     period_in = csr_wdata;
                  default: ;
               endcase
            end
            if (start) begin
               cmd_in  = req_command;
               rid_in  = req_job_id;
               rlen_in = req_job_length;
               state_in = (req_command == CMD_STEP) ? ST_STEP : ST_ADM;
            end
         end
         ST_ADM: begin
            if (held_ff == CNT_W'(MAX_JOBS)) begin
               r_rej = 1'b1;
               resp = 1'b1;
               state_in = ST_IDLE;
            end else if (fresh_ff != CNT_W'(MAX_JOBS)) begin
               nslot = fresh_ff[SLOT_W-1:0];
               fresh_in = fresh_ff + 1'b1;
               j_we = 1'b1; j_waddr = nslot; j_wdata = {rid_ff, rlen_ff, {DATA_W{1'b0}}};
               q_we = 1'b1; q_wdata = nslot;
               q_waddr = qaddr(2'(LVL_TOP), ptr_add(head_ff[0], cnt_ff[0]));
               cnt_in[0] = cnt_ff[0] + 1'b1;
               held_in = held_ff + 1'b1;
               resp = 1'b1;
               state_in = ST_IDLE;
            end else begin
               q_raddr = qaddr(RGN_FREE, SLOT_W'(free_cnt_ff - 1'b1));
               state_in = ST_ADM_POP;
            end
         end
         ST_ADM_POP: begin
            free_cnt_in = free_cnt_ff - 1'b1;
            j_we = 1'b1; j_waddr = nslot; j_wdata = {rid_ff, rlen_ff, {DATA_W{1'b0}}};
            q_we = 1'b1; q_wdata = nslot;
            q_waddr = qaddr(2'(LVL_TOP), ptr_add(head_ff[0], cnt_ff[0]));
            cnt_in[0] = cnt_ff[0] + 1'b1;
            held_in = held_ff + 1'b1;
            resp = 1'b1;
            state_in = ST_IDLE;
         end
         ST_STEP: begin
            if (held_ff == '0) begin
               resp = 1'b1;
               state_in = ST_IDLE;
            end else if (do_boost) begin
               state_in = ST_BST_RD;
            end else begin
               lvl_in = sel_lvl;
               cursor_in = sel_lvl;
               q_raddr = qaddr(sel_lvl, head_ff[sel_lvl]);
               state_in = ST_SL_JRD;
            end
         end
         ST_SL_JRD: begin
            slot_in = q_rdata;
            j_raddr = q_rdata;
            head_in[lvl_ff] = ptr_add(head_ff[lvl_ff], CNT_W'(1));
            cnt_in[lvl_ff] = cnt_ff[lvl_ff] - 1'b1;
            state_in = ST_SL_EXE;
         end
         ST_SL_EXE: begin
            jid_in   = j_rdata[JOB_W-1 -: DATA_W];
            jrem_in  = j_rdata[2*DATA_W-1 -: DATA_W];
            jused_in = j_rdata[DATA_W-1:0];
            slice_in = (jrem_in < quant) ? jrem_in : quant;
            state_in = ST_SL_WB;
         end
         ST_SL_WB: begin
            time_in = time_ff + TIME_W'(slice_ff);
            bc_in = bc_sum[BOOST_W] ? {BOOST_W{1'b1}} : bc_sum[BOOST_W-1:0];
            j_we = 1'b1;
            j_wdata = {jid_ff, rem_new, demote ? {DATA_W{1'b0}} : used_new};
            q_we = 1'b1;
            if (rem_new == '0) begin
               // completed: slot goes back on the free stack
               q_waddr = qaddr(RGN_FREE, free_cnt_ff[SLOT_W-1:0]);
               free_cnt_in = free_cnt_ff + 1'b1;
               held_in = held_ff - 1'b1;
               r_fin = 1'b1;
            end else begin
               tgt = demote ? lvl_ff + 1'b1 : lvl_ff;
               q_waddr = qaddr(tgt, ptr_add(head_ff[tgt], cnt_ff[tgt]));
               cnt_in[tgt] = cnt_ff[tgt] + 1'b1;
            end
            r_id = jid_ff; r_lvl = lvl_ff; r_slice = slice_ff; r_left = rem_new;
            resp = 1'b1;
            state_in = ST_IDLE;
         end
         ST_BST_RD: begin
            if (cnt_ff[1] != '0 || cnt_ff[2] != '0) begin
               tgt = (cnt_ff[1] != '0) ? LVL_MIDDLE : LVL_BOTTOM;
               q_raddr = qaddr(tgt, head_ff[tgt]);
               head_in[tgt] = ptr_add(head_ff[tgt], CNT_W'(1));
               cnt_in[tgt] = cnt_ff[tgt] - 1'b1;
               state_in = ST_BST_JRD;
            end else begin
               bc_in = '0;
               cursor_in = LVL_TOP;
               r_bst = 1'b1;
               resp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_BST_JRD: begin
            slot_in = q_rdata;
            j_raddr = q_rdata;
            q_we = 1'b1; q_wdata = q_rdata;
            q_waddr = qaddr(2'(LVL_TOP), ptr_add(head_ff[0], cnt_ff[0]));
            cnt_in[0] = cnt_ff[0] + 1'b1;
            state_in = ST_BST_WR;
         end
         ST_BST_WR: begin
            j_we = 1'b1;
            j_wdata = {j_rdata[JOB_W-1:DATA_W], {DATA_W{1'b0}}};
            state_in = ST_BST_RD;
         end
         default: state_in = ST_IDLE;
      endcase

      if (resp) begin
         rsp_valid_in = 1'b1;
         rsp_id_in = r_id; rsp_lvl_in = r_lvl; rsp_slice_in = r_slice;
         rsp_left_in = r_left; rsp_fin_in = r_fin; rsp_bst_in = r_bst;
         rsp_rej_in = r_rej;
         rsp_idle_in = (held_in == '0);
         rsp_time_in = time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_top_ff     <= QUANTUM_TOP_RST;
         a_top_ff     <= ALLOTMENT_TOP_RST;
         q_mid_ff     <= QUANTUM_MIDDLE_RST;
         a_mid_ff     <= ALLOTMENT_MIDDLE_RST;
         q_bot_ff     <= QUANTUM_BOTTOM_RST;
         period_ff    <= BOOST_PERIOD_RST;
         for (int l = 0; l < 3; l++) begin
            head_ff[l] <= '0;
            cnt_ff[l]  <= '0;
         end
         fresh_ff     <= '0;
         free_cnt_ff  <= '0;
         held_ff      <= '0;
         cursor_ff    <= LVL_TOP;
         bc_ff        <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_top_ff     <= q_top_in;
         a_top_ff     <= a_top_in;
         q_mid_ff     <= q_mid_in;
         a_mid_ff     <= a_mid_in;
         q_bot_ff     <= q_bot_in;
         period_ff    <= period_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         free_cnt_ff  <= free_cnt_in;
         held_ff      <= held_in;
         cursor_ff    <= cursor_in;
         bc_ff        <= bc_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rid_ff      <= rid_in;
      rlen_ff     <= rlen_in;
      lvl_ff      <= lvl_in;
      slot_ff     <= slot_in;
      jid_ff      <= jid_in;
      jrem_ff     <= jrem_in;
      jused_ff    <= jused_in;
      slice_ff    <= slice_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_slice_ff <= rsp_slice_in;
      rsp_left_ff <= rsp_left_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_bst_ff  <= rsp_bst_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_rej_ff  <= rsp_rej_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_served_id    = rsp_id_ff;
   assign rsp_served_level = rsp_lvl_ff;
   assign rsp_slice_used   = rsp_slice_ff;
   assign rsp_left_over    = rsp_left_ff;
   assign rsp_finished     = rsp_fin_ff;
   assign rsp_boosted      = rsp_bst_ff;
   assign rsp_idle         = rsp_idle_ff;
   assign rsp_rejected     = rsp_rej_ff;
   assign rsp_now_time     = rsp_time_ff;

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_finished, rsp_boosted, rsp_rejected}) <= 1)
      else $error("result carries more than one outcome");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_counts_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |->
         (CNT_W+2)'(cnt_ff[0]) + (CNT_W+2)'(cnt_ff[1]) + (CNT_W+2)'(cnt_ff[2])
            == (CNT_W+2)'(held_ff))
      else $error("queue counts disagree with held job count");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(MAX_JOBS) && held_ff == fresh_ff - free_cnt_ff)
      else $error("slot accounting broken");

   a_finish_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_left_over == '0)
      else $error("finished job with time left");

endmodule
